// ----- rtl/core/lut_linear_interp_eval_assert.svh -----
// Assertion macros for the table interpolation block.
`ifndef LUT_LINEAR_INTERP_EVAL_ASSERT_SVH
`define LUT_LINEAR_INTERP_EVAL_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define LLI_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define LLI_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ----- rtl/core/lli_pkg.sv -----
// Shared types and codes for the table interpolation block.
`timescale 1ns / 1ps

package lli_pkg;

    localparam logic [1:0] OP_EVAL   = 2'd0;
    localparam logic [1:0] OP_LOAD_S = 2'd1;
    localparam logic [1:0] OP_LOAD_V = 2'd2;

    localparam logic [2:0] CFG_ORIGIN   = 3'd0;
    localparam logic [2:0] CFG_INV_STEP = 3'd1;
    localparam logic [2:0] CFG_BINS     = 3'd2;
    localparam logic [2:0] CFG_MEANS    = 3'd3;
    localparam logic [2:0] CFG_OUTW     = 3'd4;

    localparam int BIN_MAX_W = 16;
    localparam int VA_MAX_W  = 22;

    typedef enum logic [1:0] {
        K_EVAL,
        K_LOAD_S,
        K_LOAD_V
    } t_kind;

    typedef enum logic {
        B_IDLE,
        B_RUN
    } t_bstate;

    typedef struct packed {
        logic [1:0]         op;
        logic signed [31:0] sample;
        logic [9:0]         bin;
        logic [3:0]         mean_index;
        logic signed [31:0] p_entry;
        logic signed [31:0] gx_entry;
        logic signed [31:0] gw_entry;
        logic signed [31:0] q_entry;
        logic               last_sample;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] p_value;
        logic signed [31:0] gx_value;
        logic signed [31:0] gw_value;
        logic signed [31:0] q_value;
        logic [3:0]         mean_slot;
        logic               last_of_run;
        logic               end_of_data;
    } t_out_word;

    typedef struct packed {
        t_kind                 kind;
        logic                  last_sample;
        logic [15:0]           f;
        logic [BIN_MAX_W-1:0]  xl;
        logic [BIN_MAX_W-1:0]  xh;
        logic [VA_MAX_W-1:0]   vl;
        logic [VA_MAX_W-1:0]   vh;
        logic [31:0]           data_a;
        logic [31:0]           data_b;
    } t_cmd;

    typedef struct packed {
        logic gw_on;
        logic gx_on;
        logic q_on;
    } t_outsel;

endpackage

// ----- rtl/core/lut_linear_interp_eval.sv -----
// Top level of the table lookup and linear interpolation block.
//
//  Channel  Dir  Handshake          Word
//  input    in   push / full        i_in_word  (lli_pkg::t_in_word)
//  result   out  pop / empty        o_out_word (lli_pkg::t_out_word)
//  config   in   i_cfg_we, no wait  i_cfg_idx, i_cfg_data
//
// The front takes one word per cycle, while full is low, into a 4-stage position pipeline.
// The back writes a load from its idle state and steps a sample through its run state, one word a mean.
// Reset clears control state and sets configuration to its defaults; tables stay undefined until loaded.
// full rises while the last front stage waits on a full command queue.
// The back holds issue while the result queue lacks room for the words in flight.
`timescale 1ns / 1ps

module lut_linear_interp_eval #(
    parameter int BINS  = 1024,
    parameter int MEANS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  lli_pkg::t_in_word  i_in_word,
    output logic               empty,
    input  logic               pop,
    output lli_pkg::t_out_word o_out_word,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [31:0]        i_cfg_data
);

    import lli_pkg::*;

    localparam int BIN_W     = $clog2(BINS);
    localparam int MI_W      = (MEANS > 1) ? $clog2(MEANS) : 1;
    localparam int OUT_DEPTH = 8;
    localparam int OCW       = $clog2(OUT_DEPTH + 1);
    localparam int CMD_DEPTH = 4;
    localparam logic [16:0] BINS_L  = 17'(BINS);
    localparam logic [6:0]  MEANS_L = 7'(MEANS);

    logic [31:0] r_origin;
    logic [31:0] r_inv_step;
    logic [10:0] r_bins;
    logic [4:0]  r_means;
    logic [2:0]  r_outw;

    logic [16:0]      nb_c;
    logic [6:0]       nm_c;
    logic [BIN_W-1:0] last_bin;
    logic [MI_W-1:0]  last_m;
    t_outsel          sel;

    logic      cmd_valid;
    t_cmd      cmd_in;
    t_cmd      cmd_out;
    logic      cmd_full;
    logic      cmd_empty;
    logic      cmd_pop;
    logic [$clog2(CMD_DEPTH + 1)-1:0] cmd_count;

    logic      res_push;
    t_out_word res_in;
    logic      res_full;
    logic [OCW-1:0] res_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin   <= 32'd0;
            r_inv_step <= 32'd65536;
            r_bins     <= 11'd1024;
            r_means    <= 5'd16;
            r_outw     <= 3'd4;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ORIGIN:   r_origin   <= i_cfg_data;
                CFG_INV_STEP: r_inv_step <= i_cfg_data;
                CFG_BINS:     r_bins     <= i_cfg_data[10:0];
                CFG_MEANS:    r_means    <= i_cfg_data[4:0];
                CFG_OUTW:     r_outw     <= i_cfg_data[2:0];
                default:      r_outw     <= r_outw;
            endcase
        end
    end

    always_comb begin
        if (r_bins == '0) begin
            nb_c = 17'd1;
        end else if ({6'b0, r_bins} > BINS_L) begin
            nb_c = BINS_L;
        end else begin
            nb_c = {6'b0, r_bins};
        end
        if (r_means == '0) begin
            nm_c = 7'd1;
        end else if ({2'b0, r_means} > MEANS_L) begin
            nm_c = MEANS_L;
        end else begin
            nm_c = {2'b0, r_means};
        end
        last_bin  = BIN_W'(nb_c - 17'd1);
        last_m    = MI_W'(nm_c - 7'd1);
        sel.gw_on = (r_outw >= 3'd2);
        sel.gx_on = (r_outw >= 3'd3);
        sel.q_on  = (r_outw >= 3'd4);
    end

    lli_front #(
        .BINS  (BINS),
        .MEANS (MEANS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_word      (i_in_word),
        .i_origin    (r_origin),
        .i_inv_step  (r_inv_step),
        .i_last_bin  (last_bin),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd_in),
        .i_cmd_full  (cmd_full)
    );

    lli_queue #(
        .W     ($bits(t_cmd)),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_valid),
        .i_data  (cmd_in),
        .o_full  (cmd_full),
        .i_pop   (cmd_pop),
        .o_data  (cmd_out),
        .o_empty (cmd_empty),
        .o_count (cmd_count)
    );

    lli_back #(
        .BINS      (BINS),
        .MEANS     (MEANS),
        .OUT_DEPTH (OUT_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd_out),
        .i_cmd_empty (cmd_empty || (cmd_count == '0)),
        .o_cmd_pop   (cmd_pop),
        .i_last_m    (last_m),
        .i_sel       (sel),
        .o_res_push  (res_push),
        .o_res       (res_in),
        .i_res_count (res_count)
    );

    lli_queue #(
        .W     ($bits(t_out_word)),
        .DEPTH (OUT_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push && !res_full),
        .i_data  (res_in),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (o_out_word),
        .o_empty (empty),
        .o_count (res_count)
    );

endmodule

// ----- rtl/core/lli_queue.sv -----
// Small synchronous FIFO built from registers.
`timescale 1ns / 1ps

module lli_queue #(
    parameter int W     = 8,
    parameter int DEPTH = 4,
    localparam int CW   = $clog2(DEPTH + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic [W-1:0]  i_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic [W-1:0]  o_data,
    output logic          o_empty,
    output logic [CW-1:0] o_count
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [W-1:0]  r_mem [DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_count;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_count = r_count;
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + CW'(1);
                2'b01:   r_count <= r_count - CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// ----- rtl/core/lli_front.sv -----
// Front end: accepts input words, classifies them and computes bin positions.
`timescale 1ns / 1ps

module lli_front #(
    parameter int BINS  = 1024,
    parameter int MEANS = 16,
    localparam int BIN_W = $clog2(BINS)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    output logic               o_full,
    input  lli_pkg::t_in_word  i_word,
    input  logic [31:0]        i_origin,
    input  logic [31:0]        i_inv_step,
    input  logic [BIN_W-1:0]   i_last_bin,
    output logic               o_cmd_valid,
    output lli_pkg::t_cmd      o_cmd,
    input  logic               i_cmd_full
);

    import lli_pkg::*;

    localparam int VA_W = $clog2(BINS * MEANS);
    localparam logic [16:0] BINS_L  = 17'(BINS);
    localparam logic [6:0]  MEANS_L = 7'(MEANS);

    logic               stall;
    logic               adv;
    logic               accept;
    logic signed [32:0] diff;
    logic [31:0]        d_in;
    logic               bin_ok;
    logic               mi_ok;
    logic               item_ok;
    t_cmd               c_in;
    logic [31:0]        ip;
    logic [15:0]        fr;
    logic [BIN_W-1:0]   xl;
    logic [BIN_W-1:0]   xh;
    t_cmd               c2_in;
    t_cmd               c3_in;
    logic [63:0]        prod;

    logic        r_v0;
    logic        r_v1;
    logic        r_v2;
    logic        r_v3;
    t_cmd        r_c0;
    t_cmd        r_c1;
    t_cmd        r_c2;
    t_cmd        r_c3;
    logic [31:0] r_d0;
    logic [63:0] r_p1;

    assign stall       = r_v3 && i_cmd_full;
    assign adv         = !stall;
    assign o_full      = stall;
    assign accept      = i_push && !stall;
    assign o_cmd_valid = r_v3;
    assign o_cmd       = r_c3;
    assign prod        = r_d0 * i_inv_step;

    always_comb begin
        diff   = {i_word.sample[31], i_word.sample} - {i_origin[31], i_origin};
        d_in   = (!diff[32] && (diff != '0) && (i_inv_step != '0)) ? diff[31:0] : '0;
        bin_ok = ({7'b0, i_word.bin} < BINS_L);
        mi_ok  = ({3'b0, i_word.mean_index} < MEANS_L);
        c_in             = '0;
        c_in.kind        = K_EVAL;
        c_in.last_sample = i_word.last_sample;
        item_ok          = 1'b0;
        unique case (i_word.op)
            OP_EVAL: begin
                item_ok = 1'b1;
            end
            OP_LOAD_S: begin
                c_in.kind   = K_LOAD_S;
                item_ok     = bin_ok;
                c_in.xl     = BIN_MAX_W'(i_word.bin);
                c_in.data_a = i_word.p_entry;
                c_in.data_b = i_word.gx_entry;
            end
            OP_LOAD_V: begin
                c_in.kind   = K_LOAD_V;
                item_ok     = bin_ok && mi_ok;
                c_in.vl     = VA_MAX_W'(VA_W'(32'(i_word.bin) * MEANS
                                              + 32'(i_word.mean_index)));
                c_in.data_a = i_word.gw_entry;
                c_in.data_b = i_word.q_entry;
            end
            default: begin
                item_ok = 1'b0;
            end
        endcase
    end

    always_comb begin
        ip    = r_p1[63:32];
        fr    = r_p1[31:16];
        c2_in = r_c1;
        if (ip >= 32'(i_last_bin)) begin
            xl = i_last_bin;
            xh = i_last_bin;
            c2_in.f = '0;
        end else begin
            xl = ip[BIN_W-1:0];
            xh = ip[BIN_W-1:0] + BIN_W'(fr != '0);
            c2_in.f = fr;
        end
        if (r_c1.kind == K_EVAL) begin
            c2_in.xl = BIN_MAX_W'(xl);
            c2_in.xh = BIN_MAX_W'(xh);
        end else begin
            c2_in.f = r_c1.f;
        end
    end

    always_comb begin
        c3_in = r_c2;
        if (r_c2.kind == K_EVAL) begin
            c3_in.vl = VA_MAX_W'(VA_W'(32'(r_c2.xl[BIN_W-1:0]) * MEANS));
            c3_in.vh = VA_MAX_W'(VA_W'(32'(r_c2.xh[BIN_W-1:0]) * MEANS));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (adv) begin
            r_v0 <= accept && item_ok;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_c0 <= c_in;
            r_d0 <= d_in;
            r_c1 <= r_c0;
            r_p1 <= prod;
            r_c2 <= c2_in;
            r_c3 <= c3_in;
        end
    end

endmodule

// ----- rtl/core/lli_back.sv -----
// Back end: table storage, per-mean read sequencer and interpolation pipeline.
`timescale 1ns / 1ps
`include "lut_linear_interp_eval_assert.svh"

module lli_back #(
    parameter int BINS      = 1024,
    parameter int MEANS     = 16,
    parameter int OUT_DEPTH = 8,
    localparam int MI_W     = (MEANS > 1) ? $clog2(MEANS) : 1,
    localparam int OCW      = $clog2(OUT_DEPTH + 1)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  lli_pkg::t_cmd      i_cmd,
    input  logic               i_cmd_empty,
    output logic               o_cmd_pop,
    input  logic [MI_W-1:0]    i_last_m,
    input  lli_pkg::t_outsel   i_sel,
    output logic               o_res_push,
    output lli_pkg::t_out_word o_res,
    input  logic [OCW-1:0]     i_res_count
);

    import lli_pkg::*;

    localparam int BIN_W = $clog2(BINS);
    localparam int VA_W  = $clog2(BINS * MEANS);
    localparam int OCW1  = OCW + 1;

    function automatic logic signed [49:0] lerp_mul(input logic [31:0] lo,
                                                     input logic [31:0] hi,
                                                     input logic [15:0] f);
        logic signed [32:0] d;
        logic signed [16:0] fs;
        d  = $signed({hi[31], hi}) - $signed({lo[31], lo});
        fs = $signed({1'b0, f});
        return d * fs;
    endfunction

    t_bstate r_state;
    t_bstate n_state;
    t_cmd    r_cmd;
    logic [MI_W-1:0] r_m;

    logic            issue;
    logic            credit;
    logic [OCW1-1:0] room_sum;
    logic            s_we;
    logic            v_we;
    logic [BIN_W-1:0] s_wa;
    logic [VA_W-1:0]  v_wa;
    logic [BIN_W-1:0] s_ra_l;
    logic [BIN_W-1:0] s_ra_h;
    logic [VA_W-1:0]  v_ra_l;
    logic [VA_W-1:0]  v_ra_h;

    logic [31:0] r_p_mem  [BINS];
    logic [31:0] r_gx_mem [BINS];
    logic [31:0] r_gw_mem [BINS * MEANS];
    logic [31:0] r_q_mem  [BINS * MEANS];

    logic [31:0] r_p_lo;
    logic [31:0] r_p_hi;
    logic [31:0] r_gx_lo;
    logic [31:0] r_gx_hi;
    logic [31:0] r_gw_lo;
    logic [31:0] r_gw_hi;
    logic [31:0] r_q_lo;
    logic [31:0] r_q_hi;

    logic        r_v1;
    logic [15:0] r_f1;
    logic [3:0]  r_slot1;
    logic        r_lor1;
    logic        r_eod1;

    logic               r_v2;
    logic signed [49:0] r_pp2;
    logic signed [49:0] r_gxp2;
    logic signed [49:0] r_gwp2;
    logic signed [49:0] r_qp2;
    logic [31:0]        r_plo2;
    logic [31:0]        r_gxlo2;
    logic [31:0]        r_gwlo2;
    logic [31:0]        r_qlo2;
    logic [3:0]         r_slot2;
    logic               r_lor2;
    logic               r_eod2;

    assign room_sum = OCW1'(i_res_count) + OCW1'(r_v1) + OCW1'(r_v2);
    assign credit   = (room_sum < OCW1'(OUT_DEPTH));

    assign s_wa   = i_cmd.xl[BIN_W-1:0];
    assign v_wa   = i_cmd.vl[VA_W-1:0];
    assign s_ra_l = r_cmd.xl[BIN_W-1:0];
    assign s_ra_h = r_cmd.xh[BIN_W-1:0];
    assign v_ra_l = r_cmd.vl[VA_W-1:0] + VA_W'(r_m);
    assign v_ra_h = r_cmd.vh[VA_W-1:0] + VA_W'(r_m);

    always_comb begin
        n_state   = r_state;
        o_cmd_pop = 1'b0;
        issue     = 1'b0;
        s_we      = 1'b0;
        v_we      = 1'b0;
        unique case (r_state)
            B_IDLE: begin
                if (!i_cmd_empty) begin
                    o_cmd_pop = 1'b1;
                    unique case (i_cmd.kind)
                        K_LOAD_S: s_we = 1'b1;
                        K_LOAD_V: v_we = 1'b1;
                        K_EVAL:   n_state = B_RUN;
                        default:  n_state = B_IDLE;
                    endcase
                end
            end
            B_RUN: begin
                if (credit) begin
                    issue = 1'b1;
                    if (r_m == i_last_m) begin
                        n_state = B_IDLE;
                    end
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_m     <= '0;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_v1    <= issue;
            r_v2    <= r_v1;
            if (o_cmd_pop) begin
                r_m <= '0;
            end else if (issue) begin
                r_m <= r_m + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop && (i_cmd.kind == K_EVAL)) begin
            r_cmd <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_we) begin
            r_p_mem[s_wa] <= i_cmd.data_a;
        end
        r_p_lo <= r_p_mem[s_ra_l];
        r_p_hi <= r_p_mem[s_ra_h];
    end

    always_ff @(posedge i_clk) begin
        if (s_we) begin
            r_gx_mem[s_wa] <= i_cmd.data_b;
        end
        r_gx_lo <= r_gx_mem[s_ra_l];
        r_gx_hi <= r_gx_mem[s_ra_h];
    end

    always_ff @(posedge i_clk) begin
        if (v_we) begin
            r_gw_mem[v_wa] <= i_cmd.data_a;
        end
        r_gw_lo <= r_gw_mem[v_ra_l];
        r_gw_hi <= r_gw_mem[v_ra_h];
    end

    always_ff @(posedge i_clk) begin
        if (v_we) begin
            r_q_mem[v_wa] <= i_cmd.data_b;
        end
        r_q_lo <= r_q_mem[v_ra_l];
        r_q_hi <= r_q_mem[v_ra_h];
    end

    always_ff @(posedge i_clk) begin
        r_f1    <= r_cmd.f;
        r_slot1 <= 4'(r_m);
        r_lor1  <= (r_m == i_last_m);
        r_eod1  <= (r_m == i_last_m) && r_cmd.last_sample;

        r_pp2   <= lerp_mul(r_p_lo, r_p_hi, r_f1);
        r_gxp2  <= lerp_mul(r_gx_lo, r_gx_hi, r_f1);
        r_gwp2  <= lerp_mul(r_gw_lo, r_gw_hi, r_f1);
        r_qp2   <= lerp_mul(r_q_lo, r_q_hi, r_f1);
        r_plo2  <= r_p_lo;
        r_gxlo2 <= r_gx_lo;
        r_gwlo2 <= r_gw_lo;
        r_qlo2  <= r_q_lo;
        r_slot2 <= r_slot1;
        r_lor2  <= r_lor1;
        r_eod2  <= r_eod1;
    end

    always_comb begin
        o_res_push        = r_v2;
        o_res.p_value     = r_plo2 + r_pp2[47:16];
        o_res.gx_value    = i_sel.gx_on ? (r_gxlo2 + r_gxp2[47:16]) : '0;
        o_res.gw_value    = i_sel.gw_on ? (r_gwlo2 + r_gwp2[47:16]) : '0;
        o_res.q_value     = i_sel.q_on ? (r_qlo2 + r_qp2[47:16]) : '0;
        o_res.mean_slot   = r_slot2;
        o_res.last_of_run = r_lor2;
        o_res.end_of_data = r_eod2;
    end

    `LLI_ASSERT_IMPL(a_res_room, i_clk, i_rst_n, r_v2, i_res_count < OCW'(OUT_DEPTH))
    `LLI_ASSERT_NEXT(a_last_idle, i_clk, i_rst_n, issue && (r_m == i_last_m), r_state == B_IDLE)
    `LLI_ASSERT_IMPL(a_eod_last, i_clk, i_rst_n, r_v2 && r_eod2, r_lor2)

endmodule

// ----- tb/tb_lut_linear_interp_eval.sv -----
// Self-checking testbench for the table lookup and linear interpolation block.
`timescale 1ns / 1ps

module tb_lut_linear_interp_eval;
    import lli_pkg::*;

    localparam int NBINS  = 1024;
    localparam int NMEANS = 16;
    localparam int SETTLE_CYCLES = 24;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    logic       i_clk;
    logic       i_rst_n;
    logic       push;
    logic       full;
    t_in_word   i_in_word;
    logic       empty;
    logic       pop;
    t_out_word  o_out_word;
    logic       i_cfg_we;
    logic [2:0] i_cfg_idx;
    logic [31:0] i_cfg_data;

    logic signed [31:0] cur_origin;
    logic [31:0]        cur_inv_step;
    logic [10:0]        cur_bins;
    logic [4:0]         cur_means;
    logic [2:0]         cur_outw;

    logic signed [31:0] p_tab [NBINS];
    logic signed [31:0] gx_tab [NBINS];
    logic signed [31:0] gw_tab [NBINS*NMEANS];
    logic signed [31:0] q_tab [NBINS*NMEANS];
    bit                 p_loaded [NBINS];
    bit                 v_loaded [NBINS*NMEANS];

    t_out_word   pending_words [$];
    t_out_word   next_word;
    t_in_word    dir_words [$];
    bit          dir_known [$];
    logic [31:0] dir_pval [$];
    bit          idle_on;
    int          mismatches;

    lut_linear_interp_eval #(.BINS(NBINS), .MEANS(NMEANS)) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_in_word  (i_in_word),
        .empty      (empty),
        .pop        (pop),
        .o_out_word (o_out_word),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int eff_bins();
        if (cur_bins == 0) return 1;
        if (cur_bins > NBINS) return NBINS;
        return int'(cur_bins);
    endfunction

    function automatic int eff_means();
        if (cur_means == 0) return 1;
        if (cur_means > NMEANS) return NMEANS;
        return int'(cur_means);
    endfunction

    function automatic void locate(input logic signed [31:0] s, output int xl,
                                   output int xh, output logic [15:0] f);
        longint            diff;
        logic [63:0]       prod;
        int                last;
        last = eff_bins() - 1;
        xl = 0;
        xh = 0;
        f = '0;
        diff = longint'(s) - longint'(cur_origin);
        if (diff > 0 && cur_inv_step != 0) begin
            prod = {32'd0, diff[31:0]} * {32'd0, cur_inv_step};
            if (prod[63:32] >= last) begin
                xl = last;
                xh = last;
            end else begin
                xl = int'(prod[63:32]);
                xh = xl + ((prod[31:16] != 0) ? 1 : 0);
                f = prod[31:16];
            end
        end
    endfunction

    function automatic logic [31:0] blend(input logic signed [31:0] lo,
                                          input logic signed [31:0] hi,
                                          input logic [15:0] f);
        longint d;
        d = (longint'(hi) - longint'(lo)) * longint'({1'b0, f});
        return 32'(longint'(lo) + (d >>> 16));
    endfunction

    function automatic bit safe_sample(input logic signed [31:0] s);
        int          xl;
        int          xh;
        logic [15:0] f;
        locate(s, xl, xh, f);
        if (!p_loaded[xl] || !p_loaded[xh]) return 1'b0;
        for (int m = 0; m < eff_means(); m++) begin
            if (!v_loaded[xl*NMEANS+m] || !v_loaded[xh*NMEANS+m]) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic logic [31:0] pick_sample();
        logic signed [31:0] s;
        for (int tries = 0; tries < 64; tries++) begin
            case ($urandom_range(0, 3))
                0: s = $urandom;
                1: s = cur_origin + ($urandom >> $urandom_range(0, 31));
                2: s = cur_origin - ($urandom >> $urandom_range(0, 31));
                default: s = cur_origin + ($urandom >> $urandom_range(8, 31));
            endcase
            if (safe_sample(s)) return s;
        end
        return cur_origin;
    endfunction

    function automatic void interp_sample(input t_in_word w, input bit has_p,
                                          input logic [31:0] p_typed);
        int          xl;
        int          xh;
        int          nm;
        int          ow;
        logic [15:0] f;
        logic [31:0] pv;
        logic [31:0] gxv;
        t_out_word   o;
        locate(w.sample, xl, xh, f);
        nm = eff_means();
        ow = (cur_outw == 0) ? 1 : ((cur_outw > 4) ? 4 : cur_outw);
        pv = has_p ? p_typed : blend(p_tab[xl], p_tab[xh], f);
        gxv = (ow >= 3) ? blend(gx_tab[xl], gx_tab[xh], f) : '0;
        for (int m = 0; m < nm; m++) begin
            o.p_value = pv;
            o.gx_value = gxv;
            o.gw_value = (ow >= 2) ? blend(gw_tab[xl*NMEANS+m], gw_tab[xh*NMEANS+m], f) : '0;
            o.q_value = (ow >= 4) ? blend(q_tab[xl*NMEANS+m], q_tab[xh*NMEANS+m], f) : '0;
            o.mean_slot = m[3:0];
            o.last_of_run = (m == nm - 1);
            o.end_of_data = (m == nm - 1) && w.last_sample;
            pending_words.push_back(o);
        end
    endfunction

    function automatic void track_word(input t_in_word w, input bit has_p,
                                       input logic [31:0] p_typed);
        int vi;
        vi = int'(w.bin) * NMEANS + int'(w.mean_index);
        case (w.op)
            OP_LOAD_S: begin
                p_tab[w.bin] = w.p_entry;
                gx_tab[w.bin] = w.gx_entry;
                p_loaded[w.bin] = 1'b1;
            end
            OP_LOAD_V: begin
                gw_tab[vi] = w.gw_entry;
                q_tab[vi] = w.q_entry;
                v_loaded[vi] = 1'b1;
            end
            OP_EVAL: interp_sample(w, has_p, p_typed);
            default: ;
        endcase
    endfunction

    function automatic t_in_word mk_word(input logic [1:0] op, input logic [31:0] smp,
                                         input int b, input int m, input logic [31:0] a,
                                         input logic [31:0] c, input bit last);
        t_in_word w;
        w.p_entry = $urandom;
        w.gx_entry = $urandom;
        w.gw_entry = $urandom;
        w.q_entry = $urandom;
        w.op = op;
        w.sample = smp;
        w.bin = b[9:0];
        w.mean_index = m[3:0];
        w.last_sample = last;
        if (op == OP_LOAD_S) begin
            w.p_entry = a;
            w.gx_entry = c;
        end else if (op == OP_LOAD_V) begin
            w.gw_entry = a;
            w.q_entry = c;
        end
        return w;
    endfunction

    task automatic send_word(input t_in_word w, input bit has_p, input logic [31:0] p_typed);
        while (idle_on && $urandom_range(0, 99) < 16) begin
            @(negedge i_clk);
            push <= 1'b0;
        end
        @(negedge i_clk);
        push <= 1'b1;
        i_in_word <= w;
        forever begin
            @(posedge i_clk);
            if (!full) break;
        end
        track_word(w, has_p, p_typed);
    endtask

    task automatic drain();
        @(negedge i_clk);
        push <= 1'b0;
        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
    endtask

    task automatic apply_config(input logic signed [31:0] org, input logic [31:0] inv,
                                input logic [10:0] nb, input logic [4:0] nm,
                                input logic [2:0] ow);
        write_reg(CFG_ORIGIN, org);
        write_reg(CFG_INV_STEP, inv);
        write_reg(CFG_BINS, {21'd0, nb});
        write_reg(CFG_MEANS, {27'd0, nm});
        write_reg(CFG_OUTW, {29'd0, ow});
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        cur_origin = org;
        cur_inv_step = inv;
        cur_bins = nb;
        cur_means = nm;
        cur_outw = ow;
    endtask

    task automatic fill_tables();
        int top;
        int vi;
        top = (eff_bins() < 2) ? eff_bins() : 2;
        for (int b = 0; b < eff_bins(); b++) begin
            if (b < top || b >= eff_bins() - 2) begin
                if (!p_loaded[b]) begin
                    send_word(mk_word(OP_LOAD_S, $urandom, b, 0, $urandom, $urandom, 0),
                              0, '0);
                end
                for (int m = 0; m < eff_means(); m++) begin
                    vi = b * NMEANS + m;
                    if (!v_loaded[vi]) begin
                        send_word(mk_word(OP_LOAD_V, $urandom, b, m, $urandom, $urandom, 0),
                                  0, '0);
                    end
                end
            end
        end
    endtask

    task automatic run_phase(input logic signed [31:0] org, input logic [31:0] inv,
                             input logic [10:0] nb, input logic [4:0] nm,
                             input logic [2:0] ow, input int n, input bit idle);
        int       k;
        int       b;
        t_in_word w;
        drain();
        apply_config(org, inv, nb, nm, ow);
        idle_on = idle;
        fill_tables();
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(0, 99);
            b = ($urandom_range(0, 3) == 0) ? $urandom_range(0, NBINS - 1)
                                            : $urandom_range(0, eff_bins() - 1);
            if (k < 58)
                w = mk_word(OP_EVAL, pick_sample(), b, 0, $urandom, $urandom,
                            1'($urandom_range(0, 1)));
            else if (k < 78)
                w = mk_word(OP_LOAD_S, $urandom, b, 0, $urandom, $urandom,
                            1'($urandom_range(0, 1)));
            else if (k < 96)
                w = mk_word(OP_LOAD_V, $urandom, b, $urandom_range(0, NMEANS - 1),
                            $urandom, $urandom, 1'($urandom_range(0, 1)));
            else
                w = mk_word(OP_UNUSED, $urandom, b, $urandom_range(0, NMEANS - 1),
                            $urandom, $urandom, 1'($urandom_range(0, 1)));
            send_word(w, 0, '0);
        end
    endtask

    function automatic void add_row(input t_in_word w, input bit known,
                                    input logic [31:0] pv);
        dir_words.push_back(w);
        dir_known.push_back(known);
        dir_pval.push_back(pv);
    endfunction

    task automatic cmp_field(input string name, input logic [31:0] got,
                             input logic [31:0] exp_v);
        if (got !== exp_v) begin
            $display("%0t ns: %s mismatch, expected %h, got %h", $time, name, exp_v, got);
            mismatches++;
        end
    endtask

    initial begin
        pop = 1'b0;
        forever begin
            @(negedge i_clk);
            pop <= !idle_on || ($urandom_range(0, 99) >= 16);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            if (pending_words.size() == 0) begin
                $display("%0t ns: result word with nothing expected: %h", $time, o_out_word);
                mismatches++;
            end else begin
                next_word = pending_words.pop_front();
                cmp_field("p_value", o_out_word.p_value, next_word.p_value);
                cmp_field("gx_value", o_out_word.gx_value, next_word.gx_value);
                cmp_field("gw_value", o_out_word.gw_value, next_word.gw_value);
                cmp_field("q_value", o_out_word.q_value, next_word.q_value);
                cmp_field("mean_slot", o_out_word.mean_slot, next_word.mean_slot);
                cmp_field("last_of_run", o_out_word.last_of_run, next_word.last_of_run);
                cmp_field("end_of_data", o_out_word.end_of_data, next_word.end_of_data);
            end
        end
    end

    initial begin
        i_rst_n = 1'b0;
        push = 1'b0;
        i_in_word = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        idle_on = 1'b1;
        mismatches = 0;
        cur_origin = 32'sd0;
        cur_inv_step = 32'h0001_0000;
        cur_bins = 11'd1024;
        cur_means = 5'd16;
        cur_outw = 3'd4;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset configuration: origin 0, unit step, all bins and means, all outputs
        add_row(mk_word(OP_LOAD_S, '0, 0, 0, 32'h0001_0000, 32'h8000_0000, 0), 0, '0);
        add_row(mk_word(OP_LOAD_S, '0, 1, 0, 32'h0003_0000, 32'h7FFF_FFFF, 0), 0, '0);
        add_row(mk_word(OP_LOAD_S, '0, 1022, 0, 32'h8000_0000, 32'h0000_0000, 0), 0, '0);
        add_row(mk_word(OP_LOAD_S, '0, 1023, 0, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 0), 0, '0);
        add_row(mk_word(OP_LOAD_V, '0, 0, 15, 32'h8000_0000, 32'h7FFF_FFFF, 0), 0, '0);
        add_row(mk_word(OP_LOAD_V, '0, 1, 15, 32'h7FFF_FFFF, 32'h8000_0000, 0), 0, '0);
        add_row(mk_word(OP_EVAL, 32'h0000_0000, 0, 0, '0, '0, 0), 1, 32'h0001_0000);
        add_row(mk_word(OP_EVAL, 32'h0000_8000, 0, 0, '0, '0, 0), 1, 32'h0002_0000);
        add_row(mk_word(OP_EVAL, 32'h0000_0001, 0, 0, '0, '0, 0), 1, 32'h0001_0002);
        add_row(mk_word(OP_EVAL, 32'h0000_FFFF, 0, 0, '0, '0, 0), 1, 32'h0002_FFFE);
        add_row(mk_word(OP_EVAL, 32'h8000_0000, 0, 0, '0, '0, 1), 1, 32'h0001_0000);
        add_row(mk_word(OP_EVAL, 32'h7FFF_FFFF, 0, 0, '0, '0, 0), 1, 32'h7FFF_FFFF);
        add_row(mk_word(OP_EVAL, 32'h03FE_8000, 0, 0, '0, '0, 1), 1, 32'hFFFF_FFFF);
        add_row(mk_word(OP_UNUSED, $urandom, 5, 3, $urandom, $urandom, 1), 0, '0);
        add_row(mk_word(OP_LOAD_S, '0, 1023, 0, 32'h8000_0000, 32'h7FFF_FFFF, 0), 0, '0);
        add_row(mk_word(OP_EVAL, 32'h03FF_0000, 0, 0, '0, '0, 1), 1, 32'h8000_0000);
        add_row(mk_word(OP_EVAL, 32'h03FF_FFFF, 0, 0, '0, '0, 0), 1, 32'h8000_0000);
        add_row(mk_word(OP_EVAL, 32'h0000_8000, 0, 0, '0, '0, 1), 0, '0);

        fill_tables();
        foreach (dir_words[i]) send_word(dir_words[i], dir_known[i], dir_pval[i]);

        run_phase(32'sd0, 32'h0001_0000, 11'd8, 5'd4, 3'd4, 16, 1'b0);
        run_phase(32'sh8000_0000, 32'h0000_0001, 11'd1024, 5'd16, 3'd4, 12, 1'b1);
        run_phase(32'sd0, 32'hFFFF_FFFF, 11'd2047, 5'd31, 3'd7, 12, 1'b1);
        run_phase(32'sh7FFF_FFFF, 32'h0000_0000, 11'd0, 5'd0, 3'd0, 10, 1'b1);
        run_phase(-32'sh0001_0000, 32'h0000_4000, 11'd16, 5'd16, 3'd2, 14, 1'b1);
        run_phase(32'sh0012_3456, 32'h0004_0000, 11'd1, 5'd1, 3'd3, 10, 1'b1);
        repeat (2) begin
            run_phase($urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000,
                      $urandom_range(32'h0000_2000, 32'h0008_0000),
                      11'($urandom_range(2, 32)), 5'($urandom_range(1, 16)),
                      3'($urandom_range(1, 4)), 8, 1'b1);
        end

        drain();
        if (mismatches == 0)
            $display("PASS lut_linear_interp_eval");
        else
            $display("FAIL lut_linear_interp_eval");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("FAIL lut_linear_interp_eval");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/lli_pkg.sv
rtl/core/lli_queue.sv
rtl/core/lli_front.sv
rtl/core/lli_back.sv
rtl/core/lut_linear_interp_eval.sv
tb/tb_lut_linear_interp_eval.sv
